// ===== rtl/usf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usf_pkg: shared types for the universal sink finder
// Item layouts, controller state, and command/status bundles.
// ----------------------------------------------------------------------------
package usf_pkg;

    localparam int NODE_W  = 5;
    localparam int COUNT_W = 6;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 6'd32;

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } in_item_t;

    typedef struct packed {
        logic              sink_found;
        logic [NODE_W-1:0] sink_idx;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_INIT,
        ST_Q_ELIM,
        ST_Q_COL,
        ST_Q_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic add_rd;
        logic add_wr;
        logic q_init;
        logic elim_step;
        logic elim_end;
        logic col_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic add_ok;
        logic n_zero;
        logic elim_done;
        logic col_done;
        logic out_free;
    } dp_sts_t;

endpackage : usf_pkg
`default_nettype wire

// ===== rtl/universal_sink_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// universal_sink_finder: universal sink search over an adjacency bit matrix
// Stores edges added one at a time and answers sink queries.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    in_item_t  (op, from_node, to_node)
//   m_        out        m_valid / m_ready    out_item_t (sink_found, sink_idx)
//   cfg_      in         cfg_wr_en            node_count (6 bits)
//
// An add reads the row, then writes it back; a dropped add does neither. A query
// runs candidate elimination, then the column check, one row read per cycle;
// with no nodes in use it skips both passes and goes straight to its output step.
// Reset clears all rows at once through per-row valid bits; no sweep.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a query stalls only at its end if that register is full.
// ----------------------------------------------------------------------------
module universal_sink_finder #(
    parameter int MAX_NODES = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire usf_pkg::in_item_t           s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output usf_pkg::out_item_t               m_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [usf_pkg::COUNT_W-1:0] cfg_wr_data
);
    import usf_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    state_t  state;

    usf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .state   (state)
    );

    usf_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

    a_add_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op == OP_ADD) && !m_valid |=> !m_valid)
        else $error("add transfer produced a result");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state == ST_Q_OUT))
        else $error("result raised outside the output step");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.op == OP_QUERY) |=> !s_ready)
        else $error("input ready during a query");

endmodule : universal_sink_finder
`default_nettype wire

// ===== rtl/usf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module usf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : usf_ram
`default_nettype wire

// ===== rtl/usf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usf_ctrl: sequencing controller
// Steps edge adds and the elimination and column-check passes of a query.
// ----------------------------------------------------------------------------
module usf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire usf_pkg::op_t     s_op,
    output logic                  s_ready,
    input  wire usf_pkg::dp_sts_t sts,
    output usf_pkg::dp_cmd_t      cmd,
    output usf_pkg::state_t       state
);
    import usf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = (s_op == OP_QUERY) ? ST_Q_INIT : ST_ADD_RD;
                end
            end
            ST_ADD_RD: begin
                if (sts.add_ok) begin
                    cmd.add_rd = 1'b1;
                    state_next = ST_ADD_WR;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_WR: begin
                cmd.add_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_Q_INIT: begin
                cmd.q_init = 1'b1;
                state_next = sts.n_zero ? ST_Q_OUT : ST_Q_ELIM;
            end
            ST_Q_ELIM: begin
                if (sts.elim_done) begin
                    cmd.elim_end = 1'b1;
                    state_next   = ST_Q_COL;
                end else begin
                    cmd.elim_step = 1'b1;
                end
            end
            ST_Q_COL: begin
                cmd.col_step = 1'b1;
                if (sts.col_done) begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule : usf_ctrl
`default_nettype wire

// ===== rtl/usf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usf_dp: adjacency storage and query datapath
// Row memory with per-row valid bits, candidate tracking, output register.
// ----------------------------------------------------------------------------
module usf_dp #(
    parameter int MAX_NODES = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire usf_pkg::in_item_t             s_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [usf_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire usf_pkg::dp_cmd_t              cmd,
    output usf_pkg::dp_sts_t                   sts,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output usf_pkg::out_item_t                 m_data
);
    import usf_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [COUNT_W-1:0]   nc_reg;
    in_item_t             item_reg;
    logic [MAX_NODES-1:0] vld_reg;
    logic                 rd_vld_reg;
    logic [IW-1:0]        cand_reg;
    logic [MAX_NODES-1:0] cand_row_reg;
    logic                 take_reg;
    logic                 ok_reg;
    logic [CW-1:0]        j_reg;
    logic [CW-1:0]        r_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic [CW-1:0]        n_eff;
    logic [IW-1:0]        f_idx;
    logic [IW-1:0]        j_idx;
    logic [IW-1:0]        ra;
    logic [MAX_NODES-1:0] ram_q;
    logic [MAX_NODES-1:0] row_data;
    logic [MAX_NODES-1:0] cur_row;
    logic [MAX_NODES-1:0] mask;
    logic [MAX_NODES-1:0] wr_row;
    logic [CW-1:0]        prev_r;
    logic                 col_fail;

    assign n_eff  = (int'(nc_reg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(nc_reg);
    assign f_idx  = IW'(item_reg.from_node);
    assign j_idx  = j_reg[IW-1:0];
    assign row_data = rd_vld_reg ? ram_q : '0;
    assign cur_row  = take_reg ? row_data : cand_row_reg;
    assign wr_row   = row_data | (MAX_NODES'(1) << item_reg.to_node);
    assign prev_r   = r_reg - CW'(1);
    assign col_fail = (r_reg != '0) && (prev_r != CW'(cand_reg)) && !row_data[cand_reg];

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            mask[i] = (i < int'(n_eff));
        end
    end

    always_comb begin
        ra = '0;
        if (cmd.add_rd) begin
            ra = f_idx;
        end else if (cmd.elim_step) begin
            ra = j_idx;
        end else if (cmd.col_step) begin
            ra = r_reg[IW-1:0];
        end
    end

    usf_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_rows (
        .aclk  (aclk),
        .we    (cmd.add_wr),
        .waddr (f_idx),
        .wdata (wr_row),
        .raddr (ra),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg        <= NODE_COUNT_RESET;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                nc_reg <= cfg_wr_data;
            end
            if (cmd.add_wr) begin
                vld_reg[f_idx] <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_vld_reg <= vld_reg[ra];
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.q_init) begin
            cand_reg <= '0;
            take_reg <= 1'b1;
            ok_reg   <= (n_eff != '0);
            j_reg    <= CW'(1);
        end
        if (cmd.elim_step) begin
            cand_row_reg <= cur_row;
            take_reg     <= cur_row[j_idx];
            if (cur_row[j_idx]) begin
                cand_reg <= j_idx;
            end
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.elim_end) begin
            ok_reg <= ((cur_row & mask) == '0);
            r_reg  <= '0;
        end
        if (cmd.col_step) begin
            if (col_fail) begin
                ok_reg <= 1'b0;
            end
            if (r_reg != n_eff) begin
                r_reg <= r_reg + CW'(1);
            end
        end
        if (cmd.out_load) begin
            out_reg.sink_found <= ok_reg;
            out_reg.sink_idx   <= ok_reg ? NODE_W'(cand_reg) : '0;
        end
    end

    assign sts.add_ok    = (int'(item_reg.from_node) < int'(n_eff)) &&
                           (int'(item_reg.to_node) < int'(n_eff));
    assign sts.n_zero    = (n_eff == '0);
    assign sts.elim_done = (j_reg == n_eff);
    assign sts.col_done  = (r_reg == n_eff);
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule : usf_dp
`default_nettype wire
